// ===== rtl/core/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/plist_pkg.sv =====
package plist_pkg;

  localparam int DEFAULT_CAPACITY = 128;

  // request kinds
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_FIND   = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_DEL
  } cell_mode_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_mode_t  mode;
    logic [7:0]  pos_m1;
    logic [7:0]  val;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_value;
    logic [7:0] found_position;
    logic [7:0] list_length;
    logic       is_empty;
  } result_t;

endpackage

// ===== rtl/core/positional_list_engine.sv =====
// positional list engine: an ordered list of bytes kept in a chain of cells
// input channel (in_*): one request per accepted beat, op, position, value
// output channel (out_*): exactly one result per request, in request order
// insert, delete, clear, a read at a bad position and unused op codes: a legal
//   insert or delete shifts the cells in parallel in the accept cycle, the result
//   is valid the cycle after accept, and with out_tready high they go at one per cycle
// read at a legal position and find: the chain rotates once around its
//   CAPACITY cells while the head cell is inspected, then the result is loaded
//   into the output register; the next request is taken only after that load
// the result waits in an output register; a short request is taken while
//   it drains, a legal read or a find is taken even while it is still held
// reset clears the element count, so the list starts empty; cell contents
//   need no reset since only cells below the count are ever looked at
// a stalled receiver holds the result stable and backs up the input side
module positional_list_engine
  import plist_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // op[2:0], position[10:3], value[18:11], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[1:0], read_value[9:2], found_position[17:10],
                                  // list_length[25:18], is_empty[26], zero pad
);

  cell_ctl_t  ctl;
  result_t    result;
  logic [7:0] cell_q [CAPACITY];

  // request fields
  logic [2:0] req_op;
  logic [7:0] req_pos;
  logic [7:0] req_val;

  assign req_op  = in_tdata[2:0];
  assign req_pos = in_tdata[10:3];
  assign req_val = in_tdata[18:11];

  // sequencer: holds the count, runs the scan, owns the result register
  plist_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .op        (req_op),
    .pos       (req_pos),
    .val       (req_val),
    .head_data (cell_q[0]),
    .ctl       (ctl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  // chain of cells: each takes from its left neighbor on insert and from
  // its right neighbor on delete and rotate; the last wraps to the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plist_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_i  (cell_q[(i == 0) ? 0 : i - 1]),
      .right_i (cell_q[(i + 1) % CAPACITY]),
      .data_o  (cell_q[i])
    );
  end

  // result packing, lowest field first
  assign out_tdata = {5'd0, result.is_empty, result.list_length,
                      result.found_position, result.read_value, result.status};

endmodule

// ===== rtl/core/plist_cell.sv =====
module plist_cell
  import plist_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] left_i,
  input  logic [7:0] right_i,
  output logic [7:0] data_o
);

  localparam int IW   = (INDEX > 0) ? $clog2(INDEX + 1) : 1;
  localparam int CMPW = (IW > 8) ? IW : 8;
  localparam logic [CMPW-1:0] MY_IDX = CMPW'(INDEX);

  logic [7:0]      data_r;
  logic [7:0]      data_nxt;
  logic [CMPW-1:0] pos_w;

  assign pos_w = CMPW'(ctl.pos_m1);

  always_comb begin
    unique case (ctl.mode)
      CELL_HOLD: data_nxt = data_r;
      CELL_ROT:  data_nxt = right_i;
      CELL_INS: begin
        if (MY_IDX > pos_w) begin
          data_nxt = left_i;
        end else if (MY_IDX == pos_w) begin
          data_nxt = ctl.val;
        end else begin
          data_nxt = data_r;
        end
      end
      CELL_DEL:  data_nxt = (MY_IDX >= pos_w) ? right_i : data_r;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ===== rtl/core/plist_ctrl.sv =====
`include "assert_macros.svh"

module plist_ctrl
  import plist_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] op,
  input  logic [7:0] pos,
  input  logic [7:0] val,
  input  logic [7:0] head_data,
  output cell_ctl_t  ctl,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WW = ((CW > 8) ? CW : 8) + 1;
  localparam int KW = (IW > 8) ? IW : 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t      state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [IW-1:0] k_r;
  logic        is_find_r;
  logic [7:0]  pos_m1_r;
  logic [7:0]  val_r;
  logic        found_r;
  logic [7:0]  rd_r;
  logic [7:0]  fpos_r;
  logic        out_valid_r;
  result_t     result_r;

  logic [WW-1:0] pos_w;
  logic [WW-1:0] cnt_w;
  logic        read_ok;
  logic        ins_pos_ok;
  logic        full;
  logic        is_scan;
  logic        out_free;
  logic        acc;
  logic [1:0]  status_nxt;
  logic        in_list;
  logic        out_load;

  assign pos_w      = WW'(pos);
  assign cnt_w      = WW'(count_r);
  assign read_ok    = (pos != 8'd0) && (pos_w <= cnt_w);
  assign ins_pos_ok = (pos != 8'd0) && (pos_w <= cnt_w + WW'(1));
  assign full       = (count_r == CW'(CAPACITY));
  assign is_scan    = (op == OP_FIND) || ((op == OP_READ) && read_ok);
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE) && (out_free || is_scan);
  assign acc        = in_valid && in_ready;
  assign in_list    = CW'(k_r) < count_r;
  // a new result enters the output register this cycle
  assign out_load   = ((state_r == ST_IDLE) && acc && !is_scan) ||
                      ((state_r == ST_DONE) && out_free);

  // cell broadcast
  always_comb begin
    ctl.pos_m1 = pos - 8'd1;
    ctl.val    = val;
    ctl.mode   = CELL_HOLD;
    if (state_r == ST_SCAN) begin
      ctl.mode = CELL_ROT;
    end else if (acc && (op == OP_INSERT) && ins_pos_ok && !full) begin
      ctl.mode = CELL_INS;
    end else if (acc && (op == OP_DELETE) && read_ok) begin
      ctl.mode = CELL_DEL;
    end
  end

  // result of the short requests
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    unique case (op)
      OP_READ: begin
        if (!read_ok) status_nxt = ST_BAD_POS;
      end
      OP_INSERT: begin
        if (!ins_pos_ok) begin
          status_nxt = ST_BAD_POS;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!read_ok) begin
          status_nxt = ST_BAD_POS;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      OP_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            if (is_scan) begin
              state_r   <= ST_SCAN;
              k_r       <= '0;
              is_find_r <= (op == OP_FIND);
              pos_m1_r  <= pos - 8'd1;
              val_r     <= val;
              found_r   <= 1'b0;
              rd_r      <= 8'd0;
              fpos_r    <= 8'd0;
            end else begin
              count_r                 <= count_nxt;
              result_r.status         <= status_nxt;
              result_r.read_value     <= 8'd0;
              result_r.found_position <= 8'd0;
              result_r.list_length    <= 8'(count_nxt);
              result_r.is_empty       <= (count_nxt == '0);
            end
          end
        end
        ST_SCAN: begin
          // the element at list index k sits in the head cell this cycle
          if (in_list) begin
            if (!is_find_r && (KW'(k_r) == KW'(pos_m1_r))) begin
              rd_r <= head_data;
            end
            if (is_find_r && !found_r && (head_data == val_r)) begin
              found_r <= 1'b1;
              fpos_r  <= 8'(k_r) + 8'd1;
            end
          end
          if (k_r == IW'(CAPACITY - 1)) begin
            state_r <= ST_DONE;
          end else begin
            k_r <= k_r + IW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r                 <= ST_IDLE;
            result_r.status         <= (is_find_r && !found_r) ? ST_NOT_FOUND : ST_OK;
            result_r.read_value     <= rd_r;
            result_r.found_position <= fpos_r;
            result_r.list_length    <= 8'(count_r);
            result_r.is_empty       <= (count_r == '0);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  `ASSERT_ALWAYS(a_count_range, count_r <= CW'(CAPACITY), "element count above capacity")
  `ASSERT_IMPLIES(a_busy_no_accept, state_r != ST_IDLE, !in_ready, "request taken while busy")
  `ASSERT_IMPLIES(a_scan_rotates, state_r == ST_SCAN, ctl.mode == CELL_ROT, "chain not rotating in scan")
  `ASSERT_NEXT(a_insert_grows, acc && (ctl.mode == CELL_INS),
               count_r == $past(count_r) + CW'(1), "insert did not grow the list")

endmodule
